/* rtl/core/tpc_pkg.sv */
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared types, constants and the control store of the throttle plausibility
// controller.
// ----------------------------------------------------------------------------
package tpc_pkg;

  // Field widths
  localparam int ADC_W    = 12;              // ADC count fields
  localparam int PCT_W    = 15;              // percent, 8 fraction bits
  localparam int SLIP_W   = 7;               // whole percent slip limit
  localparam int TSCALE_W = 9;               // torque scale, 1.8 fraction
  localparam int CFG_W    = 15;              // widest register
  localparam int CFG_IDX_W = 3;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 40;

  localparam logic [PCT_W-1:0] FULL_PCT = 15'd25600;

  // Quotient bits produced by the shared divider
  localparam int QUO_W   = 16;
  localparam int DCNT_W  = $clog2(QUO_W);
  // |raw - min| * FULL_PCT
  localparam int NUM_W   = 27;

  // Parameter defaults
  localparam int DEF_ADC_BITS             = 12;
  localparam int DEF_MIN_FRONT_COUNT      = 124;
  localparam int DEF_CONFLICT_BRAKE_LEVEL = 6400;
  localparam int DEF_CONFLICT_PEDAL_LEVEL = 6400;
  localparam int DEF_SWITCH_ACTIVE_HIGH   = 1;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PEDAL_A_MIN       = 3'd0,
    REG_PEDAL_A_MAX       = 3'd1,
    REG_PEDAL_B_MIN       = 3'd2,
    REG_PEDAL_B_MAX       = 3'd3,
    REG_MISMATCH_LIMIT    = 3'd4,
    REG_BRAKE_READY_LEVEL = 3'd5,
    REG_SLIP_LIMIT        = 3'd6,
    REG_TORQUE_SCALE      = 3'd7
  } reg_idx_t;

  // Register reset values
  localparam logic [ADC_W-1:0]    RST_PEDAL_A_MIN       = 12'd310;
  localparam logic [ADC_W-1:0]    RST_PEDAL_A_MAX       = 12'd2793;
  localparam logic [ADC_W-1:0]    RST_PEDAL_B_MIN       = 12'd372;
  localparam logic [ADC_W-1:0]    RST_PEDAL_B_MAX       = 12'd3351;
  localparam logic [PCT_W-1:0]    RST_MISMATCH_LIMIT    = 15'd2560;
  localparam logic [PCT_W-1:0]    RST_BRAKE_READY_LEVEL = 15'd20480;
  localparam logic [SLIP_W-1:0]   RST_SLIP_LIMIT        = 7'd5;
  localparam logic [TSCALE_W-1:0] RST_TORQUE_SCALE      = 9'd179;

  // Micro-operations
  typedef enum logic [2:0] {
    OP_NOP      = 3'd0,
    OP_TAKE     = 3'd1,   // capture the input item
    OP_DIV_LOAD = 3'd2,   // set up one scaling division
    OP_DIV_STEP = 3'd3,   // one restoring division step
    OP_STORE    = 3'd4,   // clamp quotient and store percent
    OP_EVAL1    = 3'd5,   // checks, ready latch, averaging, slip products
    OP_EVAL2    = 3'd6,   // slip decision, torque product
    OP_EMIT     = 3'd7    // final throttle into the output register
  } uop_t;

  // Operand selector for the scaling steps
  typedef enum logic [1:0] {
    SRC_A     = 2'd0,
    SRC_B     = 2'd1,
    SRC_BRAKE = 2'd2
  } src_t;

  // Jump conditions: jump to target when true, else advance
  typedef enum logic [2:0] {
    COND_NONE     = 3'd0,
    COND_ALWAYS   = 3'd1,
    COND_NO_IN    = 3'd2,
    COND_DIV_BUSY = 3'd3,
    COND_OUT_FULL = 3'd4
  } cond_t;

  localparam int STEP_W = 4;

  typedef struct packed {
    uop_t              op;
    src_t              src;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ctrl_word_t;

  // Step addresses
  localparam logic [STEP_W-1:0] ST_WAIT   = 4'd0;
  localparam logic [STEP_W-1:0] ST_A_LD   = 4'd1;
  localparam logic [STEP_W-1:0] ST_A_DIV  = 4'd2;
  localparam logic [STEP_W-1:0] ST_A_ST   = 4'd3;
  localparam logic [STEP_W-1:0] ST_B_LD   = 4'd4;
  localparam logic [STEP_W-1:0] ST_B_DIV  = 4'd5;
  localparam logic [STEP_W-1:0] ST_B_ST   = 4'd6;
  localparam logic [STEP_W-1:0] ST_BR_LD  = 4'd7;
  localparam logic [STEP_W-1:0] ST_BR_DIV = 4'd8;
  localparam logic [STEP_W-1:0] ST_BR_ST  = 4'd9;
  localparam logic [STEP_W-1:0] ST_EVAL1  = 4'd10;
  localparam logic [STEP_W-1:0] ST_EVAL2  = 4'd11;
  localparam logic [STEP_W-1:0] ST_EMIT   = 4'd12;
  localparam logic [STEP_W-1:0] ST_DONE   = 4'd13;

  // Control store
  function automatic ctrl_word_t ucode_rom(input logic [STEP_W-1:0] step);
    ctrl_word_t w;
    w = '{op: OP_NOP, src: SRC_A, cond: COND_ALWAYS, target: ST_WAIT};
    unique case (step)
      ST_WAIT:   w = '{op: OP_TAKE,     src: SRC_A,     cond: COND_NO_IN,    target: ST_WAIT};
      ST_A_LD:   w = '{op: OP_DIV_LOAD, src: SRC_A,     cond: COND_NONE,     target: ST_WAIT};
      ST_A_DIV:  w = '{op: OP_DIV_STEP, src: SRC_A,     cond: COND_DIV_BUSY, target: ST_A_DIV};
      ST_A_ST:   w = '{op: OP_STORE,    src: SRC_A,     cond: COND_NONE,     target: ST_WAIT};
      ST_B_LD:   w = '{op: OP_DIV_LOAD, src: SRC_B,     cond: COND_NONE,     target: ST_WAIT};
      ST_B_DIV:  w = '{op: OP_DIV_STEP, src: SRC_B,     cond: COND_DIV_BUSY, target: ST_B_DIV};
      ST_B_ST:   w = '{op: OP_STORE,    src: SRC_B,     cond: COND_NONE,     target: ST_WAIT};
      ST_BR_LD:  w = '{op: OP_DIV_LOAD, src: SRC_BRAKE, cond: COND_NONE,     target: ST_WAIT};
      ST_BR_DIV: w = '{op: OP_DIV_STEP, src: SRC_BRAKE, cond: COND_DIV_BUSY, target: ST_BR_DIV};
      ST_BR_ST:  w = '{op: OP_STORE,    src: SRC_BRAKE, cond: COND_NONE,     target: ST_WAIT};
      ST_EVAL1:  w = '{op: OP_EVAL1,    src: SRC_A,     cond: COND_NONE,     target: ST_WAIT};
      ST_EVAL2:  w = '{op: OP_EVAL2,    src: SRC_A,     cond: COND_NONE,     target: ST_WAIT};
      ST_EMIT:   w = '{op: OP_EMIT,     src: SRC_A,     cond: COND_OUT_FULL, target: ST_EMIT};
      ST_DONE:   w = '{op: OP_NOP,      src: SRC_A,     cond: COND_ALWAYS,   target: ST_WAIT};
      default:   w = '{op: OP_NOP,      src: SRC_A,     cond: COND_ALWAYS,   target: ST_WAIT};
    endcase
    return w;
  endfunction

endpackage

/* rtl/core/throttle_plausibility_controller.sv */
// ----------------------------------------------------------------------------
// throttle_plausibility_controller
// Pedal plausibility check, ready-to-drive latch and traction-limited
// throttle, run by a microcoded sequencer over one shared divider.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------
//  in_     | slave     | in_tvalid / in_tready | in_tdata  : one sample tick
//  out_    | master    | out_tvalid/out_tready | out_tdata : one result item
//  cfg_    | write     | cfg_we                | cfg_index, cfg_data
//
//  Each item passes through the sequencer in order: capture, three scaling
//  passes through the shared 16-step restoring divider, two evaluation
//  steps, emit and wrap. Its result enters the output register at the
//  emit step.
//  A new item is accepted once the sequencer returns to its wait step; the
//  output register holds a finished result while the next item is computed,
//  and the emit step stalls only if that register is still occupied.
//  Reset (rst_n low, synchronous) clears the ready latch, the sequencer and
//  the output valid, and loads the registers with their default values.
//
module throttle_plausibility_controller #(
  parameter int ADC_BITS             = tpc_pkg::DEF_ADC_BITS,
  parameter int MIN_FRONT_COUNT      = tpc_pkg::DEF_MIN_FRONT_COUNT,
  parameter int CONFLICT_BRAKE_LEVEL = tpc_pkg::DEF_CONFLICT_BRAKE_LEVEL,
  parameter int CONFLICT_PEDAL_LEVEL = tpc_pkg::DEF_CONFLICT_PEDAL_LEVEL,
  parameter int SWITCH_ACTIVE_HIGH   = tpc_pkg::DEF_SWITCH_ACTIVE_HIGH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata, from bit 0 up: pedal_a_raw[11:0], pedal_b_raw[23:12],
  // brake_raw[35:24], switch_raw[36], front_speed_raw[48:37],
  // rear_speed_raw[60:49], zero fill [63:61]
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [tpc_pkg::IN_DATA_W-1:0]    in_tdata,
  // out_tdata, from bit 0 up: throttle_out[14:0], brake_level[29:15],
  // ready_flag[30], ready_entered[31], sensor_mismatch[32],
  // brake_conflict[33], slip_seen[34], zero fill [39:35]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [tpc_pkg::OUT_DATA_W-1:0]   out_tdata,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [tpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tpc_pkg::CFG_W-1:0]        cfg_data
);
  import tpc_pkg::*;

  // Count bits above the converter resolution read as zero
  localparam logic [ADC_W-1:0] ADC_MASK =
    (ADC_BITS >= ADC_W) ? {ADC_W{1'b1}} : ADC_W'((1 << ADC_BITS) - 1);
  localparam logic [ADC_W-1:0] MIN_FRONT   = ADC_W'(MIN_FRONT_COUNT);
  localparam logic [PCT_W-1:0] CONF_BRAKE  = PCT_W'(CONFLICT_BRAKE_LEVEL);
  localparam logic [PCT_W-1:0] CONF_PEDAL  = PCT_W'(CONFLICT_PEDAL_LEVEL);
  localparam logic             SW_ON_LEVEL = 1'(SWITCH_ACTIVE_HIGH);
  localparam logic [DCNT_W-1:0] DCNT_LAST  = DCNT_W'(QUO_W - 1);
  localparam int SLIPP_W = 19;   // wheel-speed products
  localparam int TPROD_W = PCT_W + TSCALE_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [ADC_W-1:0]    a_min_r, a_max_r, b_min_r, b_max_r;
  logic [PCT_W-1:0]    mism_lim_r, brake_lvl_r;
  logic [SLIP_W-1:0]   slip_lim_r;
  logic [TSCALE_W-1:0] tscale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_min_r     <= RST_PEDAL_A_MIN;
      a_max_r     <= RST_PEDAL_A_MAX;
      b_min_r     <= RST_PEDAL_B_MIN;
      b_max_r     <= RST_PEDAL_B_MAX;
      mism_lim_r  <= RST_MISMATCH_LIMIT;
      brake_lvl_r <= RST_BRAKE_READY_LEVEL;
      slip_lim_r  <= RST_SLIP_LIMIT;
      tscale_r    <= RST_TORQUE_SCALE;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_PEDAL_A_MIN:       a_min_r     <= cfg_data[ADC_W-1:0];
        REG_PEDAL_A_MAX:       a_max_r     <= cfg_data[ADC_W-1:0];
        REG_PEDAL_B_MIN:       b_min_r     <= cfg_data[ADC_W-1:0];
        REG_PEDAL_B_MAX:       b_max_r     <= cfg_data[ADC_W-1:0];
        REG_MISMATCH_LIMIT:    mism_lim_r  <= cfg_data[PCT_W-1:0];
        REG_BRAKE_READY_LEVEL: brake_lvl_r <= cfg_data[PCT_W-1:0];
        REG_SLIP_LIMIT:        slip_lim_r  <= cfg_data[SLIP_W-1:0];
        REG_TORQUE_SCALE:      tscale_r    <= cfg_data[TSCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: step counter addressing the control store
  // --------------------------------------------------------------------------
  logic [STEP_W-1:0] step_r, step_nxt;
  ctrl_word_t        cw;
  logic              jump;
  logic              out_valid_r;
  logic              out_full;
  logic [DCNT_W-1:0] dcnt_r;

  assign cw        = ucode_rom(step_r);
  assign out_full  = out_valid_r && !out_tready;
  assign in_tready = (cw.op == OP_TAKE);

  always_comb begin
    unique case (cw.cond)
      COND_NONE:     jump = 1'b0;
      COND_ALWAYS:   jump = 1'b1;
      COND_NO_IN:    jump = !in_tvalid;
      COND_DIV_BUSY: jump = (dcnt_r != DCNT_LAST);
      COND_OUT_FULL: jump = out_full;
      default:       jump = 1'b1;
    endcase
    step_nxt = jump ? cw.target : step_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

  // Qualified strobes: take and emit act only when their handshake allows
  logic do_take, do_load, do_step, do_store, do_eval1, do_eval2, do_emit;
  assign do_take  = (cw.op == OP_TAKE) && in_tvalid;
  assign do_load  = (cw.op == OP_DIV_LOAD);
  assign do_step  = (cw.op == OP_DIV_STEP);
  assign do_store = (cw.op == OP_STORE);
  assign do_eval1 = (cw.op == OP_EVAL1);
  assign do_eval2 = (cw.op == OP_EVAL2);
  assign do_emit  = (cw.op == OP_EMIT) && !out_full;

  // --------------------------------------------------------------------------
  // Captured sample
  // --------------------------------------------------------------------------
  logic [ADC_W-1:0] a_raw_r, b_raw_r, br_raw_r, front_r, rear_r;
  logic             sw_r;

  always_ff @(posedge clk) begin
    if (do_take) begin
      a_raw_r  <= in_tdata[11:0]  & ADC_MASK;
      b_raw_r  <= in_tdata[23:12] & ADC_MASK;
      br_raw_r <= in_tdata[35:24] & ADC_MASK;
      sw_r     <= in_tdata[36];
      front_r  <= in_tdata[48:37] & ADC_MASK;
      rear_r   <= in_tdata[60:49] & ADC_MASK;
    end
  end

  // --------------------------------------------------------------------------
  // Shared scaling divider: pct = (raw - lo) * FULL_PCT / (hi - lo), clamped
  // --------------------------------------------------------------------------
  logic [ADC_W-1:0] sel_raw, sel_lo, sel_hi;

  always_comb begin
    case (cw.src)
      SRC_B: begin
        sel_raw = b_raw_r;
        sel_lo  = b_min_r;
        sel_hi  = b_max_r;
      end
      SRC_BRAKE: begin
        // brake shares the end points of pedal sensor A
        sel_raw = br_raw_r;
        sel_lo  = a_min_r;
        sel_hi  = a_max_r;
      end
      default: begin
        sel_raw = a_raw_r;
        sel_lo  = a_min_r;
        sel_hi  = a_max_r;
      end
    endcase
  end

  logic [ADC_W:0]   num_s, den_s;     // two's complement, one sign bit
  logic [ADC_W-1:0] num_abs, den_abs;
  logic [NUM_W-1:0] num_mag;

  always_comb begin
    num_s   = {1'b0, sel_raw} - {1'b0, sel_lo};
    den_s   = {1'b0, sel_hi} - {1'b0, sel_lo};
    num_abs = num_s[ADC_W] ? ADC_W'(-num_s) : num_s[ADC_W-1:0];
    den_abs = den_s[ADC_W] ? ADC_W'(-den_s) : den_s[ADC_W-1:0];
    num_mag = NUM_W'(num_abs) * NUM_W'(FULL_PCT);
  end

  logic [ADC_W-1:0] rem_r, den_r;
  logic [QUO_W-1:0] quo_r;            // dividend low bits, quotient shifts in
  logic             zero_r, sat_r;
  logic [ADC_W:0]   trial;
  logic             trial_ge;

  assign trial    = {rem_r, quo_r[QUO_W-1]};
  assign trial_ge = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (do_load) begin
      rem_r  <= ADC_W'(num_mag[NUM_W-1:QUO_W]);
      quo_r  <= num_mag[QUO_W-1:0];
      den_r  <= den_abs;
      dcnt_r <= '0;
      // empty range, or opposite signs: quotient is zero or below
      zero_r <= (den_abs == '0) || (num_s[ADC_W] != den_s[ADC_W]);
      // quotient would not fit the divider width: clamp to full scale
      sat_r  <= ({1'b0, num_mag[NUM_W-1:QUO_W]} >= den_abs);
    end else if (do_step) begin
      rem_r  <= trial_ge ? ADC_W'(trial - {1'b0, den_r}) : trial[ADC_W-1:0];
      quo_r  <= {quo_r[QUO_W-2:0], trial_ge};
      dcnt_r <= dcnt_r + 1'b1;
    end
  end

  logic [PCT_W-1:0] pct_res;

  always_comb begin
    if (zero_r) begin
      pct_res = '0;
    end else if (sat_r || (quo_r > QUO_W'(FULL_PCT))) begin
      pct_res = FULL_PCT;
    end else begin
      pct_res = quo_r[PCT_W-1:0];
    end
  end

  logic [PCT_W-1:0] pa_r, pb_r, brake_r;

  always_ff @(posedge clk) begin
    if (do_store) begin
      case (cw.src)
        SRC_B:     pb_r    <= pct_res;
        SRC_BRAKE: brake_r <= pct_res;
        default:   pa_r    <= pct_res;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // First evaluation: mismatch, ready latch, average, conflict, slip products
  // --------------------------------------------------------------------------
  logic             ready_r;
  logic             mism_r, entered_r, conf_r, front_ok_r, slip_r;
  logic [PCT_W-1:0] thr1_r;
  logic [SLIPP_W-1:0] wd100_r, limf_r;
  logic [TPROD_W-1:0] tprod_r;

  logic [PCT_W-1:0] pdiff, avg, thr_pre;
  logic             mism, enter, conf;
  logic [ADC_W-1:0] wd;

  always_comb begin
    pdiff   = (pa_r > pb_r) ? pa_r - pb_r : pb_r - pa_r;
    mism    = (pdiff > mism_lim_r);
    enter   = !ready_r && (brake_r >= brake_lvl_r) && (sw_r == SW_ON_LEVEL) && !mism;
    avg     = PCT_W'(({1'b0, pa_r} + {1'b0, pb_r}) >> 1);
    thr_pre = mism ? '0 : avg;
    // judged on the average after mismatch zeroing
    conf    = (brake_r > CONF_BRAKE) && (thr_pre > CONF_PEDAL);
    wd      = (rear_r > front_r) ? rear_r - front_r : front_r - rear_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r <= 1'b0;
    end else if (do_eval1 && enter) begin
      ready_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_eval1) begin
      mism_r     <= mism;
      entered_r  <= enter;
      conf_r     <= conf;
      thr1_r     <= conf ? '0 : thr_pre;
      front_ok_r <= (front_r > MIN_FRONT);
      wd100_r    <= SLIPP_W'(wd) * SLIPP_W'(100);
      limf_r     <= SLIPP_W'(slip_lim_r) * SLIPP_W'(front_r);
    end
  end

  // --------------------------------------------------------------------------
  // Second evaluation: slip decision and reduced-torque product
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (do_eval2) begin
      slip_r  <= front_ok_r && (wd100_r > limf_r);
      tprod_r <= TPROD_W'(thr1_r) * TPROD_W'(tscale_r);
    end
  end

  // --------------------------------------------------------------------------
  // Emit: saturated reduced throttle on slip, else the unreduced one; zero while not ready
  // --------------------------------------------------------------------------
  logic [QUO_W-1:0] scaled;
  logic [PCT_W-1:0] scaled_sat, thr_fin;

  always_comb begin
    scaled     = tprod_r[TPROD_W-1:8];
    scaled_sat = (scaled > QUO_W'(FULL_PCT)) ? FULL_PCT : scaled[PCT_W-1:0];
    if (!ready_r) begin
      thr_fin = '0;
    end else if (slip_r) begin
      thr_fin = scaled_sat;
    end else begin
      thr_fin = thr1_r;
    end
  end

  // Output register: holds a result until the item is taken
  logic [OUT_DATA_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (do_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_emit) begin
      out_data_r <= {5'b0, slip_r, conf_r, mism_r, entered_r, ready_r, brake_r, thr_fin};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
